### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/rsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared constants, codes and memory port bundles of the slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam int NUM_SLOTS  = 256;
   localparam int COUNT_BITS = 16;
   localparam int ID_BITS    = $clog2(NUM_SLOTS);
   localparam int TOP_BITS   = ID_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [ID_BITS-1:0]    ID_MAX    = ID_BITS'(NUM_SLOTS - 1);

   // request codes
   localparam logic [1:0] REQ_ACQUIRE = 2'd0;
   localparam logic [1:0] REQ_RETAIN  = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;
   localparam logic [1:0] REQ_QUERY   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_INVALID      = 2'd1;
   localparam logic [1:0] ST_FULL         = 2'd2;
   localparam logic [1:0] ST_ZERO_RELEASE = 2'd3;

   typedef struct packed {
      logic               en;
      logic [ID_BITS-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic                  en;
      logic [ID_BITS-1:0]    addr;
      logic [COUNT_BITS-1:0] data;
   } ref_wr_type;

   typedef struct packed {
      logic               en;
      logic [ID_BITS-1:0] addr;
      logic [ID_BITS-1:0] data;
   } stk_wr_type;

endpackage

### rtl/refcounted_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_allocator
// Hands out slot ids from a LIFO free list and keeps a count per slot.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall) carries one request word: req_type
//   (acquire, retain, release, query) and req_tile_id. rsp channel
//   (rsp_valid / rsp_stall) returns exactly one word per request: id,
//   count after the operation, status and the live / peak / allocated
//   counters as they stand after the request.
//   A word accepted in S_IDLE is shown on rsp once S_EXEC loads the output
//   register. A new request is not taken until the last one has left S_EXEC.
//   S_IDLE reads the count memory and the free stack top on the accept edge;
//   S_EXEC runs the shared count unit and writes both memories back.
//   req_stall is high whenever a request is in flight. If rsp_stall holds
//   a finished word, the next request waits in S_EXEC until the
//   output register frees up; the rsp word holds steady while stalled.
//   Reset (synchronous, active high) empties the free stack and clears all
//   counters; no clearing pass is needed because count entries are only
//   used for ids up to the high-water mark, each written when first handed out.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_type,
   input  logic [rsa_pkg::ID_BITS-1:0]    req_tile_id,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rsa_pkg::ID_BITS-1:0]    rsp_result_id,
   output logic [rsa_pkg::COUNT_BITS-1:0] rsp_ref_count,
   output logic [1:0]                     rsp_status,
   output logic [rsa_pkg::ID_BITS-1:0]    rsp_live_count,
   output logic [rsa_pkg::ID_BITS-1:0]    rsp_peak_count,
   output logic [rsa_pkg::ID_BITS-1:0]    rsp_allocated_count
);

   localparam logic S_IDLE = 1'b0;   // waiting for a request
   localparam logic S_EXEC = 1'b1;   // read data back, modify and write

   // sequencer and captured request
   logic                            state_ff, state_in;
   logic [1:0]                      op_ff;
   logic [rsa_pkg::ID_BITS-1:0]     id_ff;
   logic                            id_ok_ff;

   // allocator state
   logic [rsa_pkg::TOP_BITS-1:0]    free_top_ff, free_top_in;
   logic [rsa_pkg::ID_BITS-1:0]     high_water_ff, high_water_in;
   logic [rsa_pkg::ID_BITS-1:0]     live_ff, live_in;
   logic [rsa_pkg::ID_BITS-1:0]     peak_ff, peak_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rsa_pkg::ID_BITS-1:0]     rsp_id_ff, rsp_id_in;
   logic [rsa_pkg::COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;

   logic                            accept;
   logic                            out_free;
   logic                            fire;

   rsa_pkg::mem_rd_type             ref_rd, stk_rd;
   rsa_pkg::ref_wr_type             ref_wr;
   rsa_pkg::stk_wr_type             stk_wr;
   logic [rsa_pkg::COUNT_BITS-1:0]  ref_rd_data;
   logic [rsa_pkg::ID_BITS-1:0]     stk_rd_data;

   logic                            alu_dec;
   logic [rsa_pkg::COUNT_BITS-1:0]  alu_result;
   logic                            alu_operand_zero;
   logic                            alu_result_zero;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == S_EXEC) && out_free;

   // Both memories are read on the accept edge; the stack is read at its
   // top entry in case this is an acquire that pops.
   always_comb begin
      ref_rd.en   = accept;
      ref_rd.addr = req_tile_id;
      stk_rd.en   = accept;
      stk_rd.addr = rsa_pkg::ID_BITS'(free_top_ff - rsa_pkg::TOP_BITS'(1));
   end

   rsa_ref_store u_ref_store (
      .clock   (clock),
      .rd      (ref_rd),
      .wr      (ref_wr),
      .rd_data (ref_rd_data)
   );

   rsa_free_stack u_free_stack (
      .clock   (clock),
      .rd      (stk_rd),
      .wr      (stk_wr),
      .rd_data (stk_rd_data)
   );

   assign alu_dec = (op_ff == rsa_pkg::REQ_RELEASE);

   rsa_count_alu u_count_alu (
      .op_dec       (alu_dec),
      .operand      (ref_rd_data),
      .result       (alu_result),
      .operand_zero (alu_operand_zero),
      .result_zero  (alu_result_zero)
   );

   // Execute step: decide the outcome, schedule writes and the response.
   always_comb begin
      free_top_in   = free_top_ff;
      high_water_in = high_water_ff;
      live_in       = live_ff;
      peak_in       = peak_ff;
      rsp_id_in     = id_ff;
      rsp_count_in  = '0;
      rsp_status_in = rsa_pkg::ST_OK;
      ref_wr        = '0;
      stk_wr        = '0;

      unique case (op_ff)
         rsa_pkg::REQ_ACQUIRE: begin
            if (free_top_ff != '0) begin
               // reuse the most recently freed id
               free_top_in  = free_top_ff - rsa_pkg::TOP_BITS'(1);
               rsp_id_in    = stk_rd_data;
               rsp_count_in = rsa_pkg::COUNT_BITS'(1);
            end else if (high_water_ff != rsa_pkg::ID_MAX) begin
               // fresh id above the high-water mark
               high_water_in = high_water_ff + rsa_pkg::ID_BITS'(1);
               rsp_id_in     = high_water_ff + rsa_pkg::ID_BITS'(1);
               rsp_count_in  = rsa_pkg::COUNT_BITS'(1);
            end else begin
               rsp_id_in     = '0;
               rsp_status_in = rsa_pkg::ST_FULL;
            end
            if (rsp_status_in == rsa_pkg::ST_OK) begin
               ref_wr.en   = fire;
               ref_wr.addr = rsp_id_in;
               ref_wr.data = rsa_pkg::COUNT_BITS'(1);
               live_in     = live_ff + rsa_pkg::ID_BITS'(1);
               if (live_in > peak_ff) begin
                  peak_in = live_in;
               end
            end
         end
         rsa_pkg::REQ_RETAIN: begin
            if (!id_ok_ff || alu_operand_zero) begin
               // a freed slot is not revived by retain
               rsp_status_in = rsa_pkg::ST_INVALID;
            end else begin
               ref_wr.en    = fire;
               ref_wr.addr  = id_ff;
               ref_wr.data  = alu_result;
               rsp_count_in = alu_result;
            end
         end
         rsa_pkg::REQ_RELEASE: begin
            if (!id_ok_ff) begin
               rsp_status_in = rsa_pkg::ST_INVALID;
            end else if (alu_operand_zero) begin
               rsp_status_in = rsa_pkg::ST_ZERO_RELEASE;
            end else begin
               ref_wr.en    = fire;
               ref_wr.addr  = id_ff;
               ref_wr.data  = alu_result;
               rsp_count_in = alu_result;
               if (alu_result_zero) begin
                  // last reference gone: back on the free list
                  if (free_top_ff < rsa_pkg::TOP_BITS'(rsa_pkg::NUM_SLOTS)) begin
                     stk_wr.en   = fire;
                     stk_wr.addr = rsa_pkg::ID_BITS'(free_top_ff);
                     stk_wr.data = id_ff;
                     free_top_in = free_top_ff + rsa_pkg::TOP_BITS'(1);
                  end
                  if (live_ff != '0) begin
                     live_in = live_ff - rsa_pkg::ID_BITS'(1);
                  end
               end
            end
         end
         rsa_pkg::REQ_QUERY: begin
            if (!id_ok_ff) begin
               rsp_status_in = rsa_pkg::ST_INVALID;
            end else begin
               rsp_count_in = ref_rd_data;
            end
         end
         default: begin
            rsp_status_in = rsa_pkg::ST_INVALID;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_top_ff   <= '0;
         high_water_ff <= '0;
         live_ff       <= '0;
         peak_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            free_top_ff   <= free_top_in;
            high_water_ff <= high_water_in;
            live_ff       <= live_in;
            peak_ff       <= peak_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_type;
         id_ff    <= req_tile_id;
         id_ok_ff <= (req_tile_id != '0) && (req_tile_id <= high_water_ff);
      end
      if (fire) begin
         rsp_id_ff     <= rsp_id_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_id       = rsp_id_ff;
   assign rsp_ref_count       = rsp_count_ff;
   assign rsp_status          = rsp_status_ff;
   // counters are only updated on the edge that loads a response
   assign rsp_live_count      = live_ff;
   assign rsp_peak_count      = peak_ff;
   assign rsp_allocated_count = high_water_ff;

endmodule

### rtl/rsa_count_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_count_alu
// Shared count unit: increment saturating at the maximum, or plain decrement, by one with flags.
// ----------------------------------------------------------------------------
module rsa_count_alu (
   input  logic                           op_dec,
   input  logic [rsa_pkg::COUNT_BITS-1:0] operand,
   output logic [rsa_pkg::COUNT_BITS-1:0] result,
   output logic                           operand_zero,
   output logic                           result_zero
);

   logic at_max;

   assign at_max       = (operand == rsa_pkg::COUNT_MAX);
   assign operand_zero = (operand == '0);

   always_comb begin
      if (op_dec) begin
         result = operand - rsa_pkg::COUNT_BITS'(1);
      end else if (at_max) begin
         result = operand;
      end else begin
         result = operand + rsa_pkg::COUNT_BITS'(1);
      end
   end

   assign result_zero = (result == '0);

endmodule

### rtl/rsa_ref_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_ref_store
// Reference count memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsa_ref_store (
   input  logic                           clock,
   input  rsa_pkg::mem_rd_type            rd,
   input  rsa_pkg::ref_wr_type            wr,
   output logic [rsa_pkg::COUNT_BITS-1:0] rd_data
);

   logic [rsa_pkg::COUNT_BITS-1:0] ref_mem_ff [rsa_pkg::NUM_SLOTS];
   logic [rsa_pkg::COUNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ref_mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= ref_mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rsa_free_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_free_stack
// Storage of freed ids, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsa_free_stack (
   input  logic                        clock,
   input  rsa_pkg::mem_rd_type         rd,
   input  rsa_pkg::stk_wr_type         wr,
   output logic [rsa_pkg::ID_BITS-1:0] rd_data
);

   logic [rsa_pkg::ID_BITS-1:0] stk_mem_ff [rsa_pkg::NUM_SLOTS];
   logic [rsa_pkg::ID_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         stk_mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= stk_mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [rsa_pkg::ID_BITS-1:0]    rsp_result_id,
   input logic [rsa_pkg::COUNT_BITS-1:0] rsp_ref_count,
   input logic [1:0]                     rsp_status,
   input logic [rsa_pkg::ID_BITS-1:0]    rsp_live_count,
   input logic [rsa_pkg::ID_BITS-1:0]    rsp_peak_count
);

   logic rsp_full;
   logic rsp_reject;
   logic rsp_held;
   logic [3*rsa_pkg::ID_BITS+rsa_pkg::COUNT_BITS+1:0] rsp_word;

   assign rsp_full   = rsp_valid && (rsp_status == rsa_pkg::ST_FULL);
   assign rsp_reject = rsp_valid && (rsp_status == rsa_pkg::ST_INVALID ||
                                     rsp_status == rsa_pkg::ST_ZERO_RELEASE);
   assign rsp_held   = rsp_valid && rsp_stall;
   assign rsp_word   = {rsp_result_id, rsp_ref_count, rsp_status,
                        rsp_live_count, rsp_peak_count};

   // one request in flight at a time
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a full store grants nothing
   `ASSERT_IMPLY(a_full_no_grant, clock, reset, rsp_full, rsp_result_id == '0 && rsp_ref_count == '0)

   // rejected requests report a zero count
   `ASSERT_IMPLY(a_reject_zero_count, clock, reset, rsp_reject, rsp_ref_count == '0)

   // peak never trails live
   `ASSERT_IMPLY(a_peak_covers_live, clock, reset, rsp_valid, rsp_peak_count >= rsp_live_count)

   // a stalled response word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word))

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_result_id  (rsp_result_id),
   .rsp_ref_count  (rsp_ref_count),
   .rsp_status     (rsp_status),
   .rsp_live_count (rsp_live_count),
   .rsp_peak_count (rsp_peak_count)
);
